FILE: rtl/trp_pkg.sv
// ----------------------------------------------------------------------------
// trp_pkg
// shared constants, register codes and the lane control bundle of the
// three-axis rate pid core
// ----------------------------------------------------------------------------
package trp_pkg;

  localparam int AXES = 3;

  // field widths
  localparam int GYRO_W   = 16;
  localparam int TILT_W   = 12;
  localparam int TGT_W    = 10;
  localparam int DT_W     = 16;
  localparam int GAIN_W   = 8;
  localparam int MODE_W   = 3;
  localparam int DRIVE_W  = 23;
  localparam int IDX_W    = 3;

  // internal widths
  localparam int ERR_W    = 19;
  localparam int INT_W    = 27;
  localparam int DSC_W    = 31;
  localparam int MAG_W    = 34;
  localparam int FACD_W   = 12;
  localparam int INT_SH   = 13;

  // divide by 10000: shift right four, then multiply by the rounded-up
  // reciprocal of 625 scaled by 2^40, exact for a 30-bit dividend
  localparam int RECIP_W  = 31;
  localparam int RECIP_SH = 40;
  localparam int QUO_W    = 21;
  localparam logic [RECIP_W-1:0] RECIP_625 = 31'd1759218605;

  // register indexes
  localparam logic [IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [IDX_W-1:0] REG_PGAIN = 3'd1;
  localparam logic [IDX_W-1:0] REG_IGAIN = 3'd2;
  localparam logic [IDX_W-1:0] REG_DGAIN = 3'd3;
  localparam logic [IDX_W-1:0] REG_LGAIN = 3'd4;

  // flight modes, everything else is self-level
  localparam logic [MODE_W-1:0] MODE_ZERO  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_STICK = 3'd4;
  localparam logic [MODE_W-1:0] MODE_GYRO  = 3'd5;

  // reset values
  localparam logic [MODE_W-1:0] MODE_RST  = 3'd0;
  localparam logic [GAIN_W-1:0] PGAIN_RST = 8'd200;
  localparam logic [GAIN_W-1:0] IGAIN_RST = 8'd200;
  localparam logic [GAIN_W-1:0] DGAIN_RST = 8'd100;
  localparam logic [GAIN_W-1:0] LGAIN_RST = 8'd15;

  localparam logic [DT_W-1:0]   FACTOR_NUM = 16'hFFFF;
  localparam logic signed [31:0] I_LIMIT   = 32'sd40960000;

  // phase strobes from the sequencer to every lane
  typedef struct packed {
    logic clr;
    logic ph_a;
    logic ph_b;
    logic ph_c;
    logic go;
    logic ph_e;
    logic ph_f;
    logic ph_g;
    logic ph_h;
  } lane_ctl_t;

endpackage

FILE: rtl/trp_divider.sv
// ----------------------------------------------------------------------------
// trp_divider
// iterative restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module trp_divider #(
  parameter int NW = 16,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [NW-1:0] quotient,
  output logic          done
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem, num[NW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(NW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      num <= {num[NW-2:0], fits};
      if (fits) begin
        rem <= DW'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[DW-1:0];
      end
    end
  end

  assign quotient = num;

endmodule

FILE: rtl/trp_lane.sv
// ----------------------------------------------------------------------------
// trp_lane
// one axis: target rate, error, p term, clamped integrator, smoothed d term
// ----------------------------------------------------------------------------
module trp_lane import trp_pkg::*; #(
  parameter int AXIS = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  lane_ctl_t                 ctl,
  input  logic [MODE_W-1:0]         mode,
  input  logic signed [GYRO_W-1:0]  gyro,
  input  logic signed [TILT_W-1:0]  tilt,
  input  logic signed [TGT_W-1:0]   target,
  input  logic [DT_W-1:0]           dt,
  input  logic [DT_W-1:0]           factor,
  input  logic [GAIN_W-1:0]         p_gain,
  input  logic [GAIN_W-1:0]         i_gain,
  input  logic [GAIN_W-1:0]         d_gain,
  input  logic [GAIN_W-1:0]         l_gain,
  output logic                      done,
  output logic [DRIVE_W-1:0]        drive
);

  // state
  logic signed [INT_W-1:0] integ;
  logic signed [ERR_W-1:0] prev_err;
  logic signed [DSC_W-1:0] delta_older;
  logic signed [DSC_W-1:0] delta_newer;

  // working registers
  logic signed [23:0]      lvl_prod;
  logic signed [ERR_W-1:0] err;
  logic signed [27:0]      p_prod;
  logic signed [ERR_W:0]   diff;
  logic [MAG_W-1:0]        dt_mag;
  logic                    dt_neg;
  logic [MAG_W+RECIP_W-5:0] q_prod;
  logic signed [21:0]      q_signed;
  logic signed [36:0]      d_prod;
  logic signed [30:0]      i_step;
  logic signed [32:0]      d_sum;
  logic signed [41:0]      d_gain_prod;
  logic [DRIVE_W-1:0]      result;

  logic signed [14:0]      lvl_diff;
  logic signed [17:0]      want;
  logic signed [35:0]      dt_prod;
  logic [QUO_W-1:0]        quo;
  logic signed [DSC_W-1:0] d_scaled;
  logic signed [31:0]      i_sum;
  logic [DRIVE_W-1:0]      p_part;
  logic [DRIVE_W-1:0]      i_part;
  logic [DRIVE_W-1:0]      d_part;
  logic [DRIVE_W-1:0]      pid;

  assign lvl_diff = 15'(target) * 15'sd10 - 15'(tilt);

  always_comb begin
    want = '0;
    if (AXIS < 2) begin
      case (mode)
        MODE_ZERO:  want = '0;
        MODE_STICK: want = 18'(target) * 18'sd4;
        MODE_GYRO:  want = 18'(gyro);
        default:    want = 18'(lvl_prod >>> 4);
      endcase
    end
  end

  assign dt_prod  = err * $signed({1'b0, dt});
  assign d_scaled = DSC_W'(d_prod >>> 6);
  assign i_sum    = 32'(integ) + 32'(i_step);

  // quotient magnitude of the divide by 10000 stays below 2^20
  assign quo = q_prod[RECIP_SH+QUO_W-1:RECIP_SH];

  always_ff @(posedge clk) begin
    if (ctl.ph_a) lvl_prod <= lvl_diff * $signed({1'b0, l_gain});
    if (ctl.ph_b) err <= ERR_W'(want) - ERR_W'(gyro);
    if (ctl.ph_c) begin
      p_prod <= err * $signed({1'b0, p_gain});
      diff   <= (ERR_W+1)'(err) - (ERR_W+1)'(prev_err);
      dt_neg <= dt_prod < 0;
      dt_mag <= dt_prod < 0 ? MAG_W'(-dt_prod) : MAG_W'(dt_prod);
    end
    if (ctl.go) q_prod <= dt_mag[MAG_W-1:4] * RECIP_625;
    if (ctl.ph_e) begin
      q_signed <= dt_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      d_prod   <= diff * $signed({1'b0, factor});
    end
    if (ctl.ph_f) begin
      i_step <= q_signed * $signed({1'b0, i_gain});
      d_sum  <= 33'(delta_newer) + 33'(delta_older) + 33'(d_scaled);
    end
    if (ctl.ph_g) d_gain_prod <= d_sum * $signed({1'b0, d_gain});
    if (ctl.ph_h) result <= DRIVE_W'(pid * 23'd10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ       <= '0;
      prev_err    <= '0;
      delta_older <= '0;
      delta_newer <= '0;
      done        <= 1'b0;
    end else begin
      if (ctl.ph_a) begin
        done <= 1'b0;
      end else if (ctl.go) begin
        done <= 1'b1;
      end
      if (ctl.clr) integ <= '0;
      if (ctl.ph_c) prev_err <= err;
      if (ctl.ph_f) begin
        delta_older <= delta_newer;
        delta_newer <= d_scaled;
      end
      if (ctl.ph_g) begin
        if (i_sum < -I_LIMIT) begin
          integ <= INT_W'(-I_LIMIT);
        end else if (i_sum > I_LIMIT) begin
          integ <= INT_W'(I_LIMIT);
        end else begin
          integ <= INT_W'(i_sum);
        end
      end
    end
  end

  // the sum only matters modulo the output width
  assign p_part = DRIVE_W'(p_prod >>> 7);
  assign i_part = DRIVE_W'(integ >>> INT_SH);
  assign d_part = DRIVE_W'(d_gain_prod >>> 8);
  assign pid    = p_part + i_part + d_part;
  assign drive  = result;

endmodule

FILE: rtl/three_axis_rate_pid_core.sv
// ----------------------------------------------------------------------------
// three_axis_rate_pid_core
// roll, pitch and yaw rate pid with angle self-levelling, one lane per axis
// ----------------------------------------------------------------------------
// usage
//   s_* : one control tick per item (gyro rates, angles, stick targets,
//         tick length, integrator clear)
//   m_* : one item per tick with the three drive values
//   cfg_* : register writes (mode and gains), always ready, to be done
//         while no tick is in flight
// the time from input accept to output valid is set by the 16-step divider
//   forming the d scale factor, while the divide by 10000 in each lane is a
//   reciprocal multiply registered beside it
// a new tick is taken only once the last has left the sequencer; s_tready is
//   high only while the sequencer is idle
// a finished result waits in the output register; if the receiver stalls,
//   the next tick is taken and computed, then held before the output stage
//   until the register frees
// reset clears integrators, error history, d history, output valid and
//   loads the register defaults
// ----------------------------------------------------------------------------
module three_axis_rate_pid_core import trp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // gyro_roll, gyro_pitch, gyro_yaw, tilt_roll, tilt_pitch, target_x,
  // target_y, tick_length, clear_integrators, zero pad to 112
  input  logic [111:0]         s_tdata,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // drive_roll, drive_pitch, drive_yaw, zero pad to 72
  output logic [71:0]          m_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // register write port
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data
);

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_A    = 4'd1;
  localparam logic [3:0] S_B    = 4'd2;
  localparam logic [3:0] S_C    = 4'd3;
  localparam logic [3:0] S_GO   = 4'd4;
  localparam logic [3:0] S_WAIT = 4'd5;
  localparam logic [3:0] S_E    = 4'd6;
  localparam logic [3:0] S_F    = 4'd7;
  localparam logic [3:0] S_G    = 4'd8;
  localparam logic [3:0] S_H    = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  // configuration registers
  logic [MODE_W-1:0] mode;
  logic [GAIN_W-1:0] p_gain;
  logic [GAIN_W-1:0] i_gain;
  logic [GAIN_W-1:0] d_gain;
  logic [GAIN_W-1:0] l_gain;

  // captured item
  logic signed [GYRO_W-1:0] gyro [AXES];
  logic signed [TILT_W-1:0] tilt [2];
  logic signed [TGT_W-1:0]  tgt  [2];
  logic [DT_W-1:0]          dt;
  logic                     clr;

  logic [AXES-1:0]          lane_done;
  logic [DRIVE_W-1:0]       lane_drive [AXES];
  logic                     fac_done;
  logic [DT_W-1:0]          factor;
  logic [FACD_W-1:0]        fac_div;
  lane_ctl_t                ctl;
  logic                     in_acc;

  assign in_acc    = s_tvalid && s_tready;
  assign s_tready  = state == S_IDLE;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_RST;
      p_gain <= PGAIN_RST;
      i_gain <= IGAIN_RST;
      d_gain <= DGAIN_RST;
      l_gain <= LGAIN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:  mode   <= cfg_data[MODE_W-1:0];
        REG_PGAIN: p_gain <= cfg_data;
        REG_IGAIN: i_gain <= cfg_data;
        REG_DGAIN: d_gain <= cfg_data;
        REG_LGAIN: l_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      gyro[0] <= s_tdata[15:0];
      gyro[1] <= s_tdata[31:16];
      gyro[2] <= s_tdata[47:32];
      tilt[0] <= s_tdata[59:48];
      tilt[1] <= s_tdata[71:60];
      tgt[0]  <= s_tdata[81:72];
      tgt[1]  <= s_tdata[91:82];
      dt      <= s_tdata[107:92];
      clr     <= s_tdata[108];
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_acc) state_next = S_A;
      S_A:    state_next = S_B;
      S_B:    state_next = S_C;
      S_C:    state_next = S_GO;
      S_GO:   state_next = S_WAIT;
      S_WAIT: if (&lane_done && fac_done) state_next = S_E;
      S_E:    state_next = S_F;
      S_F:    state_next = S_G;
      S_G:    state_next = S_H;
      S_H:    state_next = S_OUT;
      S_OUT:  if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl      = '0;
    ctl.clr  = state == S_A && clr;
    ctl.ph_a = state == S_A;
    ctl.ph_b = state == S_B;
    ctl.ph_c = state == S_C;
    ctl.go   = state == S_GO;
    ctl.ph_e = state == S_E;
    ctl.ph_f = state == S_F;
    ctl.ph_g = state == S_G;
    ctl.ph_h = state == S_H;
  end

  // d scale factor, a short tick counts as one
  assign fac_div = dt[DT_W-1:4] == '0 ? FACD_W'(1) : dt[DT_W-1:4];

  trp_divider #(.NW(DT_W), .DW(FACD_W)) u_fac_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.go),
    .dividend (FACTOR_NUM),
    .divisor  (fac_div),
    .quotient (factor),
    .done     (fac_done)
  );

  // axis lanes, yaw sees no tilt or stick
  for (genvar a = 0; a < AXES; a++) begin : g_lane
    trp_lane #(.AXIS(a)) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .mode   (mode),
      .gyro   (gyro[a]),
      .tilt   (a < 2 ? tilt[a % 2] : '0),
      .target (a < 2 ? tgt[a % 2] : '0),
      .dt     (dt),
      .factor (factor),
      .p_gain (p_gain),
      .i_gain (i_gain),
      .d_gain (d_gain),
      .l_gain (l_gain),
      .done   (lane_done[a]),
      .drive  (lane_drive[a])
    );
  end

  // merge the lanes into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {3'b000, lane_drive[2], lane_drive[1], lane_drive[0]};
    end
  end

  // checks
  a_accept_starts : assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == S_A)
    else $error("accepted item did not start the sequencer");

  a_dividers_done : assert property (@(posedge clk) disable iff (rst)
    state == S_E |-> (&lane_done && fac_done))
    else $error("results used before the dividers finished");

  a_hold_result : assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && m_tvalid && !m_tready) |=> state == S_OUT)
    else $error("new result left the output stage over a pending one");

  a_no_accept_busy : assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_tready)
    else $error("input ready while a tick is in progress");

endmodule

FILE: tb/three_axis_rate_pid_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_axis_rate_pid_core_tb
// self-checking bench: directed and random control ticks through the rate pid
// core across several register settings, results compared per axis against a
// behavioural predictor of the controller state
// ----------------------------------------------------------------------------
module three_axis_rate_pid_core_tb;
  import trp_pkg::*;

  typedef struct packed {
    logic               clr_int;
    logic [DT_W-1:0]    tick;
    logic signed [TGT_W-1:0]  tgt_y;
    logic signed [TGT_W-1:0]  tgt_x;
    logic signed [TILT_W-1:0] tilt_p;
    logic signed [TILT_W-1:0] tilt_r;
    logic signed [GYRO_W-1:0] gyro_y;
    logic signed [GYRO_W-1:0] gyro_p;
    logic signed [GYRO_W-1:0] gyro_r;
  } tick_t;

  typedef struct {
    logic [DRIVE_W-1:0] drive [3];
  } drive_t;

  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [111:0] s_tdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [71:0] m_tdata;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0] cfg_data = '0;

  three_axis_rate_pid_core i_dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // predictor state, mirrors the controller registers and per-axis history
  logic [MODE_W-1:0] mode_q;
  longint p_gain, i_gain, d_gain, l_gain;
  longint integ [3];
  longint prev_err [3];
  longint d_old [3];
  longint d_new [3];

  tick_t  pending_ticks[$];
  drive_t expected_drives[$];
  int     errors = 0;
  int     idle_cycles = 0;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic string drive_name(int a);
    case (a)
      0: return "drive_roll";
      1: return "drive_pitch";
      default: return "drive_yaw";
    endcase
  endfunction

  // one control tick through the predictor, updates state
  function automatic drive_t predict_drive(tick_t t);
    drive_t r;
    longint gyro [3];
    longint tilt [2];
    longint tgt [2];
    longint dt, dv, fac, want, err, p, i, d, diff, sum;
    gyro[0] = t.gyro_r; gyro[1] = t.gyro_p; gyro[2] = t.gyro_y;
    tilt[0] = t.tilt_r; tilt[1] = t.tilt_p;
    tgt[0] = t.tgt_x;   tgt[1] = t.tgt_y;
    dt = longint'(t.tick);
    if (t.clr_int) begin
      for (int a = 0; a < 3; a++) integ[a] = 0;
    end
    dv = dt >>> 4;
    if (dv == 0) dv = 1;
    fac = 65535 / dv;
    for (int a = 0; a < 3; a++) begin
      if (a == 2 || mode_q == MODE_ZERO) want = 0;
      else if (mode_q == MODE_STICK) want = tgt[a] * 4;
      else if (mode_q == MODE_GYRO) want = gyro[a];
      else want = asr((10 * tgt[a] - tilt[a]) * l_gain, 4);
      err = want - gyro[a];
      p = asr(err * p_gain, 7);
      // integer division in sv truncates toward zero as required
      integ[a] += ((err * dt) / 10000) * i_gain;
      if (integ[a] < -40960000) integ[a] = -40960000;
      else if (integ[a] > 40960000) integ[a] = 40960000;
      i = asr(integ[a], 13);
      diff = err - prev_err[a];
      prev_err[a] = err;
      diff = asr(diff * fac, 6);
      sum = d_new[a] + d_old[a] + diff;
      d_old[a] = d_new[a];
      d_new[a] = diff;
      d = asr(sum * d_gain, 8);
      r.drive[a] = DRIVE_W'((p + i + d) * 10);
    end
    return r;
  endfunction

  function automatic tick_t random_tick(bit sane);
    tick_t t;
    t.gyro_r = $urandom; t.gyro_p = $urandom; t.gyro_y = $urandom;
    if (sane && $urandom_range(0, 1)) begin
      // small rates keep the integrators out of the clamp
      t.gyro_r = $urandom_range(0, 600) - 300;
      t.gyro_p = $urandom_range(0, 600) - 300;
      t.gyro_y = $urandom_range(0, 600) - 300;
    end
    t.tilt_r = $urandom_range(0, 3600) - 1800;
    t.tilt_p = $urandom_range(0, 3600) - 1800;
    t.tgt_x = $urandom; t.tgt_y = $urandom;
    t.tick = sane ? 16'($urandom_range(10001, 65535)) : 16'($urandom);
    t.clr_int = ($urandom_range(0, 15) == 0);
    return t;
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MODE:  mode_q = val[MODE_W-1:0];
      REG_PGAIN: p_gain = val;
      REG_IGAIN: i_gain = val;
      REG_DGAIN: d_gain = val;
      REG_LGAIN: l_gain = val;
      default: ;
    endcase
  endtask

  task automatic settle;
    while (pending_ticks.size() != 0 || expected_drives.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // driver: bursts of items with random gaps
  int gap = 0, burst = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_drives.push_back(predict_drive(pending_ticks.pop_front()));
      end
      if (s_tvalid && !(s_tready)) begin
        // keep offering the same item
      end else if (gap > 0) begin
        gap <= gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_ticks.size() != 0) begin
        if (burst <= 1 && s_tvalid) begin
          gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 80);
          burst <= $urandom_range(1, 6);
          s_tvalid <= 1'b0;
        end else begin
          if (s_tvalid) burst <= burst - 1;
          s_tvalid <= 1'b1;
          s_tdata <= 112'(pending_ticks[0]);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, plus one long hold-off after the 31st result
  int stall_phase = 0;
  int hold_cnt = 0;
  int outs_seen = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (!rst && m_tvalid && m_tready) outs_seen <= outs_seen + 1;
    if (!rst && m_tvalid && m_tready && outs_seen == 30) hold_cnt <= 600;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
    if (rst || hold_cnt > 0) m_tready <= 1'b0;
    else if (stall_phase[9]) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  // monitor: check each item against the oldest expectation
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (m_tvalid && m_tready) begin
        if (expected_drives.size() == 0) begin
          $error("unexpected item on output: %h", m_tdata);
          errors++;
        end else begin
          drive_t e;
          e = expected_drives.pop_front();
          for (int a = 0; a < 3; a++)
            if (m_tdata[a*DRIVE_W +: DRIVE_W] !== e.drive[a]) begin
              $error("%s expected %0d actual %0d", drive_name(a),
                     $signed(e.drive[a]), $signed(m_tdata[a*DRIVE_W +: DRIVE_W]));
              errors++;
            end
        end
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic run_random(int n);
    for (int k = 0; k < n; k++) pending_ticks.push_back(random_tick($urandom_range(0, 9) != 0));
    settle();
  endtask

  initial begin
    tick_t t;
    mode_q = MODE_RST; p_gain = 200; i_gain = 200; d_gain = 100; l_gain = 15;
    for (int a = 0; a < 3; a++) begin
      integ[a] = 0; prev_err[a] = 0; d_old[a] = 0; d_new[a] = 0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, short tick, clear, each mode
    t = '0; t.tick = 16'd10001; pending_ticks.push_back(t);
    t.gyro_r = 16'sh7FFF; t.gyro_p = 16'sh8000; t.gyro_y = 16'sh7FFF;
    t.tilt_r = 12'sd1800; t.tilt_p = -12'sd1800; t.tgt_x = 10'sd511; t.tgt_y = -10'sd512;
    t.tick = 16'hFFFF; pending_ticks.push_back(t); pending_ticks.push_back(t);
    t.gyro_r = 16'sh8000; t.gyro_p = 16'sh7FFF; t.gyro_y = 16'sh8000;
    t.tgt_x = -10'sd512; t.tgt_y = 10'sd511; t.tilt_r = -12'sd1800; t.tilt_p = 12'sd1800;
    pending_ticks.push_back(t);
    t.tick = 16'd5; pending_ticks.push_back(t);      // short tick, divisor 1
    t.tick = 16'd0; pending_ticks.push_back(t);
    t.clr_int = 1'b1; t.tick = 16'd20000; pending_ticks.push_back(t);
    t.clr_int = 1'b0; pending_ticks.push_back(t);
    settle();
    for (int m = 0; m < 8; m++) begin
      write_reg(REG_MODE, GAIN_W'(m));
      for (int k = 0; k < 2; k++) pending_ticks.push_back(random_tick(1'b1));
      settle();
    end

    // default gains, self-level, the receiver's long hold-off falls in here
    write_reg(REG_MODE, GAIN_W'(MODE_RST));
    for (int k = 0; k < 10; k++) pending_ticks.push_back(random_tick(1'b1));
    run_random(140);

    // extremes of every gain
    write_reg(REG_PGAIN, 8'd255); write_reg(REG_IGAIN, 8'd255);
    write_reg(REG_DGAIN, 8'd255); write_reg(REG_LGAIN, 8'd255);
    write_reg(REG_MODE, GAIN_W'(MODE_STICK));
    run_random(120);
    write_reg(REG_PGAIN, 8'd0); write_reg(REG_IGAIN, 8'd0);
    write_reg(REG_DGAIN, 8'd0); write_reg(REG_LGAIN, 8'd0);
    write_reg(REG_MODE, GAIN_W'(MODE_GYRO));
    run_random(80);
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_MODE, GAIN_W'($urandom_range(0, 7)));
      write_reg(REG_PGAIN, GAIN_W'($urandom)); write_reg(REG_IGAIN, GAIN_W'($urandom));
      write_reg(REG_DGAIN, GAIN_W'($urandom)); write_reg(REG_LGAIN, GAIN_W'($urandom));
      run_random(70);
    end

    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
